// ===== src/mgbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mgbs_pkg
// Shared types and constants for the minimum graph bisection search core.
// ----------------------------------------------------------------------------
package mgbs_pkg;

    // Default sizing of the graph store
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_WEIGHT_BITS  = 16;

    // Fixed field widths on the ports
    localparam int FUNC_W      = 2;
    localparam int VERTEX_W    = 4;
    localparam int WEIGHT_IN_W = 16;
    localparam int VCOUNT_W    = 5;
    localparam int COST_OUT_W  = 23;
    localparam int MASK_OUT_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic [COST_OUT_W-1:0] COST_OUT_MAX = '1;
    localparam logic [VCOUNT_W-1:0]   VCOUNT_RESET = 5'd16;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SOLVE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_EVAL   = 3'd2,
        ST_ROW    = 3'd3,
        ST_UPDATE = 3'd4,
        ST_FINISH = 3'd5
    } state_t;

endpackage : mgbs_pkg
`default_nettype wire

// ===== src/mgbs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mgbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mgbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : mgbs_ram
`default_nettype wire

// ===== src/min_graph_bisection_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_graph_bisection_search_core
// Exhaustive minimum equal-size graph bisection over a stored edge-weight
// matrix, walked in Gray-code order with one shared adder.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Content
//  s_*     | in  | s_tvalid / s_tready  | write edge, clear, solve items
//  m_*     | out | m_tvalid / m_tready  | best cost, best mask, odd flag
//  cfg_*   | in  | cfg_valid / cfg_ready| vertex_count register
//
//  Clear: one RAM entry per cycle over all MAX_VERTICES^2 entries.
//  Solve: each Gray-code step reads one matrix row through the single RAM
//  read port.
//  Reset starts the same clearing pass; items wait for it, config writes
//  are taken at any time.
//  A finished result sits in the output register; a following solve holds
//  in its final state until that register is free.
// ----------------------------------------------------------------------------
module min_graph_bisection_search_core
    import mgbs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [3:0] vertex_a, [7:4] vertex_b,
                                                 // [23:8] edge_weight_in
    input  wire logic [FUNC_W-1:0]     s_tuser,  // [1:0] func
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // [22:0] min_cost, [38:23] best_mask,
                                                 // [39] zero
    output logic      [0:0]            m_tuser,  // [0] odd_error
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [VCOUNT_W-1:0]   cfg_data  // [4:0] vertex_count
);

    // derived sizes
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = MAX_VERTICES + 1;
    localparam int PAIRS = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int CW    = WEIGHT_BITS + $clog2(PAIRS + 1);
    localparam int DW    = CW + 1;
    localparam int XW    = (CW > COST_OUT_W) ? CW : COST_OUT_W;
    localparam int MXW   = (MAX_VERTICES > MASK_OUT_W) ? MAX_VERTICES : MASK_OUT_W;
    localparam int WXW   = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

    // matrix entry address of an unordered pair, stored as (low, high)
    function automatic logic [AW-1:0] pair_addr(input logic [VW-1:0] p, input logic [VW-1:0] q);
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        return AW'(AW'(lo) * AW'(MAX_VERTICES)) + AW'(hi);
    endfunction

    // input fields
    logic [VERTEX_W-1:0]    in_a;
    logic [VERTEX_W-1:0]    in_b;
    logic [WEIGHT_IN_W-1:0] in_w;
    func_t                  in_func;
    logic                   in_acc;
    logic [WXW-1:0]         in_w_x;

    assign in_a    = s_tdata[3:0];
    assign in_b    = s_tdata[7:4];
    assign in_w    = s_tdata[23:8];
    assign in_func = func_t'(s_tuser);
    assign in_acc  = s_tvalid && s_tready;
    assign in_w_x  = WXW'(in_w);

    // registers
    state_t                  state_reg,   state_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic [VCOUNT_W-1:0]     vcount_reg;
    logic [NW-1:0]           n_reg,       n_next;
    logic [TW-1:0]           limit_reg,   limit_next;
    logic [TW-1:0]           t_reg,       t_next;
    logic [MAX_VERTICES-1:0] mask_reg,    mask_next;
    logic [NW-1:0]           pop_reg,     pop_next;
    logic [CW-1:0]           cost_reg,    cost_next;
    logic signed [DW-1:0]    delta_reg,   delta_next;
    logic [VW-1:0]           k_reg,       k_next;
    logic [NW-1:0]           j_reg,       j_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [VW-1:0]           pend_j_reg,  pend_j_next;
    logic [CW-1:0]           low_cost_reg, low_cost_next;
    logic [MAX_VERTICES-1:0] best_mask_reg, best_mask_next;
    logic                    found_reg,   found_next;
    logic                    odd_reg,     odd_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    // RAM port
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WEIGHT_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WEIGHT_BITS-1:0] ram_rdata;

    mgbs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective vertex count, capped at the store size
    logic [VCOUNT_W-1:0] vcount_cap;
    logic [NW-1:0]       n_eff;

    assign vcount_cap = (vcount_reg > VCOUNT_W'(MAX_VERTICES)) ?
                        VCOUNT_W'(MAX_VERTICES) : vcount_reg;
    assign n_eff      = NW'(vcount_cap);

    // lowest set bit of the step counter picks the vertex to move
    logic [VW-1:0] flip_k;

    always_comb
    begin
        flip_k = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (t_reg[i])
            begin
                flip_k = VW'(i);
            end
        end
    end

    // candidate check against the best split so far
    logic better;

    assign better = (pop_reg == (n_reg >> 1)) &&
                    (!found_reg || (cost_reg < low_cost_reg) ||
                     ((cost_reg == low_cost_reg) && (mask_reg < best_mask_reg)));

    // shared adder
    logic signed [DW-1:0] add_a;
    logic signed [DW-1:0] add_b;
    logic signed [DW-1:0] add_sum;
    logic signed [DW-1:0] w_s;
    logic                 same_side;

    assign add_sum   = add_a + add_b;
    assign w_s       = signed'(DW'(ram_rdata));
    assign same_side = (mask_reg[pend_j_reg] == mask_reg[k_reg]);

    // result formatting with saturation
    logic [XW-1:0]         low_cost_x;
    logic [COST_OUT_W-1:0] cost_out;
    logic [MXW-1:0]        best_mask_x;

    assign low_cost_x  = XW'(low_cost_reg);
    assign cost_out    = (low_cost_x > XW'(COST_OUT_MAX)) ?
                         COST_OUT_MAX : low_cost_x[COST_OUT_W-1:0];
    assign best_mask_x = MXW'(best_mask_reg);

    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && (in_func == FUNC_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (in_acc && (in_func == FUNC_SOLVE))
                begin
                    state_next = n_eff[0] ? ST_FINISH : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = (t_reg == limit_reg) ? ST_FINISH : ST_ROW;
            end
            ST_ROW:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_EVAL;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        n_next         = n_reg;
        limit_next     = limit_reg;
        t_next         = t_reg;
        mask_next      = mask_reg;
        pop_next       = pop_reg;
        cost_next      = cost_reg;
        delta_next     = delta_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        pend_vld_next  = 1'b0;
        pend_j_next    = pend_j_reg;
        low_cost_next  = low_cost_reg;
        best_mask_next = best_mask_reg;
        found_next     = found_reg;
        odd_next       = odd_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = pair_addr(VW'(in_a), VW'(in_b));
        ram_wdata      = in_w_x[WEIGHT_BITS-1:0];
        ram_raddr      = pair_addr(k_reg, VW'(j_reg));
        add_a          = delta_reg;
        add_b          = w_s;
        s_tready       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                clr_addr_next = '0;
                if (in_acc && (in_func == FUNC_WRITE) &&
                    (VCOUNT_W'(in_a) < VCOUNT_W'(MAX_VERTICES)) &&
                    (VCOUNT_W'(in_b) < VCOUNT_W'(MAX_VERTICES)))
                begin
                    ram_we = 1'b1;
                end
                if (in_acc && (in_func == FUNC_SOLVE))
                begin
                    n_next         = n_eff;
                    limit_next     = TW'(1) << n_eff;
                    t_next         = TW'(1);
                    mask_next      = '0;
                    pop_next       = '0;
                    cost_next      = '0;
                    low_cost_next  = '0;
                    best_mask_next = '0;
                    found_next     = 1'b0;
                    odd_next       = n_eff[0];
                end
            end
            ST_EVAL:
            begin
                if (better)
                begin
                    low_cost_next  = cost_reg;
                    best_mask_next = mask_reg;
                    found_next     = 1'b1;
                end
                k_next     = flip_k;
                j_next     = '0;
                delta_next = '0;
            end
            ST_ROW:
            begin
                // issue one row read per cycle, accumulate the previous one
                if (j_reg < n_reg)
                begin
                    pend_vld_next = 1'b1;
                    pend_j_next   = VW'(j_reg);
                    j_next        = j_reg + NW'(1);
                end
                add_a = delta_reg;
                add_b = same_side ? w_s : -w_s;
                if (pend_vld_reg && (pend_j_reg != k_reg))
                begin
                    delta_next = add_sum;
                end
            end
            ST_UPDATE:
            begin
                add_a     = signed'(DW'(cost_reg));
                add_b     = delta_reg;
                cost_next = CW'(add_sum);
                mask_next = mask_reg ^ (MAX_VERTICES'(1) << k_reg);
                pop_next  = mask_reg[k_reg] ? (pop_reg - NW'(1)) : (pop_reg + NW'(1));
                t_next    = t_reg + TW'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = odd_reg ? '0 :
                                    {1'b0, best_mask_x[MASK_OUT_W-1:0], cost_out};
                    m_tuser_next  = odd_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            vcount_reg   <= VCOUNT_RESET;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        limit_reg     <= limit_next;
        t_reg         <= t_next;
        mask_reg      <= mask_next;
        pop_reg       <= pop_next;
        cost_reg      <= cost_next;
        delta_reg     <= delta_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        pend_j_reg    <= pend_j_next;
        low_cost_reg  <= low_cost_next;
        best_mask_reg <= best_mask_next;
        found_reg     <= found_next;
        odd_reg       <= odd_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // checks
    logic [TW-1:0]           t_prev;
    logic [MAX_VERTICES-1:0] gray_chk;

    assign t_prev   = t_reg - TW'(1);
    assign gray_chk = MAX_VERTICES'(t_prev ^ (t_prev >> 1));

    // an odd-count result carries no cost and no mask
    a_odd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("odd result with nonzero payload");

    // the population counter follows the current split
    a_pop_track: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EVAL) || (state_reg == ST_ROW) || (state_reg == ST_UPDATE))
        |-> ($countones(mask_reg) == int'(pop_reg)))
        else $error("population count out of step with mask");

    // each evaluated split is the Gray code of its step number minus one
    a_gray_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (mask_reg == gray_chk))
        else $error("split sequence left Gray-code order");

    // the matrix is only written while idle or clearing
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_IDLE) || (state_reg == ST_CLEAR)))
        else $error("matrix write during a solve");

endmodule : min_graph_bisection_search_core
`default_nettype wire
